/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock, disabled in reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on every clock
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hdl/vcs_pkg.sv */
//------------------------------------------------------------------------------
// vcs_pkg
// shared types and register indexes for the velocity command saturator
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package vcs_pkg;
	localparam int VW = 24;
	localparam int FB = 16;
	localparam int LW = 23;

	typedef struct packed {
		logic signed [VW-1:0] forward_in;
		logic signed [VW-1:0] sideways_in;
		logic signed [VW-1:0] turn_in;
	} cmd_in_t;

	typedef struct packed {
		logic signed [VW-1:0] forward_out;
		logic signed [VW-1:0] sideways_out;
		logic signed [VW-1:0] turn_out;
	} cmd_out_t;

	localparam logic [2:0] REG_FWD  = 3'd0;
	localparam logic [2:0] REG_BWD  = 3'd1;
	localparam logic [2:0] REG_SIDE = 3'd2;
	localparam logic [2:0] REG_LIN  = 3'd3;
	localparam logic [2:0] REG_TURN = 3'd4;
	localparam logic [2:0] REG_PROP = 3'd5;
endpackage

/* hdl/vcs_fifo.sv */
//------------------------------------------------------------------------------
// vcs_fifo
// two-entry queue between the front and the back of the saturator
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module vcs_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  vcs_pkg::cmd_in_t     wdata,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output vcs_pkg::cmd_in_t     rdata
);
	vcs_pkg::cmd_in_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* hdl/vcs_core.sv */
//------------------------------------------------------------------------------
// vcs_core
// sequencer that limits one command: ratio divisions, scaling, norm limit
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module vcs_core #(
	parameter int VEL_WIDTH = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [VEL_WIDTH-1:0] fx_i,
	input  logic signed [VEL_WIDTH-1:0] fy_i,
	input  logic signed [VEL_WIDTH-1:0] w_i,
	input  logic [VEL_WIDTH-2:0]        lim_f,
	input  logic [VEL_WIDTH-2:0]        lim_b,
	input  logic [VEL_WIDTH-2:0]        lim_s,
	input  logic [VEL_WIDTH-2:0]        lim_l,
	input  logic [VEL_WIDTH-2:0]        lim_t,
	input  logic                        prop,
	output logic                        busy,
	output logic                        done,
	output logic signed [VEL_WIDTH-1:0] fx_o,
	output logic signed [VEL_WIDTH-1:0] fy_o,
	output logic signed [VEL_WIDTH-1:0] w_o
);
	localparam int MW = VEL_WIDTH;          // magnitude width
	localparam int RW = FRAC_BITS + 1;      // ratio width (up to 1.0)
	localparam int NW = VEL_WIDTH - 1 + FRAC_BITS; // dividend width
	localparam int SW = 2 * MW + 2;         // sum of squares width, even for bit pairs
	localparam int QW = MW + 1;             // root width
	localparam int CW = $clog2(NW + 2);
	localparam logic [RW-1:0] ONE = RW'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_DIVX, S_DIVY, S_DIVW, S_SCALE, S_SQ, S_ROOT, S_DIVL, S_LSC, S_DONE
	} st_t;
	st_t st_q;

	logic [MW-1:0] mx_q, my_q, mw_q;
	logic          nx_q, ny_q, nw_q;
	logic [RW-1:0] rx_q, ry_q, rw_q;
	logic          lx_q, ly_q, lw_q;   // axis needs a division
	logic [MW-1:0] dlx_q, dly_q, dlw_q; // limit used for that axis
	logic [SW-1:0] s_q, rem_q;
	logic [QW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	// shared restoring divider
	logic [NW-1:0] dq_q;
	logic [MW:0]   dr_q;
	logic [MW-1:0] dd_q;

	// divider step
	logic [MW:0] dr_sh;
	logic        dr_ge;
	assign dr_sh = {dr_q[MW-1:0], dq_q[NW-1]};
	assign dr_ge = dr_sh >= {1'b0, dd_q};

	// root step: two bits at a time, one result bit
	logic [SW-1:0] rt_rem_sh, rt_trial;
	assign rt_rem_sh = {rem_q[SW-3:0], s_q[SW-1:SW-2]};
	assign rt_trial  = {{(SW-QW-2){1'b0}}, root_q, 2'b01};

	logic [RW-1:0] rmin;
	always_comb begin
		rmin = rx_q;
		if (ry_q < rmin) rmin = ry_q;
		if (rw_q < rmin) rmin = rw_q;
	end

	// scale products
	logic [MW+RW-1:0] px, py, pw;
	logic [RW-1:0] sx, sy, sw;
	assign sx = prop ? rmin : rx_q;
	assign sy = prop ? rmin : ry_q;
	assign sw = prop ? rmin : rw_q;
	assign px = MW'(mx_q) * sx;
	assign py = MW'(my_q) * sy;
	assign pw = MW'(mw_q) * sw;

	// norm limit products
	logic [MW+RW-1:0] plx, ply;
	assign plx = (MW+RW)'(mx_q) * rx_q;
	assign ply = (MW+RW)'(my_q) * rx_q;

	logic [SW-1:0] sq_lim;
	assign sq_lim = SW'(lim_l) * SW'(lim_l);

	logic [MW-1:0] ax_i, ay_i, aw_i;
	assign ax_i = fx_i[VEL_WIDTH-1] ? MW'(-fx_i) : MW'(fx_i);
	assign ay_i = fy_i[VEL_WIDTH-1] ? MW'(-fy_i) : MW'(fy_i);
	assign aw_i = w_i[VEL_WIDTH-1] ? MW'(-w_i) : MW'(w_i);

	logic [NW-1:0] quo_next;
	assign quo_next = {dq_q[NW-2:0], dr_ge};

	assign busy = st_q != S_IDLE;
	assign fx_o = nx_q ? -$signed(mx_q) : $signed(mx_q);
	assign fy_o = ny_q ? -$signed(my_q) : $signed(my_q);
	assign w_o  = nw_q ? -$signed(mw_q) : $signed(mw_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: if (start) begin
					mx_q <= ax_i; my_q <= ay_i; mw_q <= aw_i;
					nx_q <= fx_i[VEL_WIDTH-1]; ny_q <= fy_i[VEL_WIDTH-1];
					nw_q <= w_i[VEL_WIDTH-1];
					rx_q <= ONE; ry_q <= ONE; rw_q <= ONE;
					lx_q <= (!fx_i[VEL_WIDTH-1] && ax_i > MW'(lim_f)) ||
						(fx_i[VEL_WIDTH-1] && lim_b != '0 && ax_i > MW'(lim_b));
					dlx_q <= fx_i[VEL_WIDTH-1] ? MW'(lim_b) : MW'(lim_f);
					ly_q <= ay_i > MW'(lim_s); dly_q <= MW'(lim_s);
					lw_q <= aw_i > MW'(lim_t); dlw_q <= MW'(lim_t);
					cnt_q <= '0;
					st_q <= S_DIVX;
				end
				S_DIVX, S_DIVY, S_DIVW, S_DIVL: begin
					if (cnt_q == '0) begin
						// load divider
						case (st_q)
							S_DIVX:  dd_q <= mx_q;
							S_DIVY:  dd_q <= my_q;
							S_DIVW:  dd_q <= mw_q;
							default: dd_q <= root_q[MW-1:0];
						endcase
						case (st_q)
							S_DIVX:  dq_q <= {dlx_q[MW-2:0], {FRAC_BITS{1'b0}}};
							S_DIVY:  dq_q <= {dly_q[MW-2:0], {FRAC_BITS{1'b0}}};
							S_DIVW:  dq_q <= {dlw_q[MW-2:0], {FRAC_BITS{1'b0}}};
							default: dq_q <= {lim_l, {FRAC_BITS{1'b0}}};
						endcase
						dr_q <= '0;
						cnt_q <= CW'(1);
					end else if (cnt_q <= CW'(NW)) begin
						dr_q <= dr_ge ? dr_sh - {1'b0, dd_q} : dr_sh;
						dq_q <= quo_next;
						cnt_q <= cnt_q + CW'(1);
					end else begin
						// quotient is below 1.0 here for axis limits
						cnt_q <= '0;
						case (st_q)
							S_DIVX: begin
								if (lx_q) rx_q <= dq_q[RW-1:0];
								st_q <= S_DIVY;
							end
							S_DIVY: begin
								if (ly_q) ry_q <= dq_q[RW-1:0];
								st_q <= S_DIVW;
							end
							S_DIVW: begin
								if (lw_q) rw_q <= dq_q[RW-1:0];
								st_q <= S_SCALE;
							end
							default: begin
								rx_q <= dq_q[RW-1:0];
								st_q <= S_LSC;
							end
						endcase
					end
				end
				S_SCALE: begin
					mx_q <= MW'(px >> FRAC_BITS);
					my_q <= MW'(py >> FRAC_BITS);
					mw_q <= MW'(pw >> FRAC_BITS);
					st_q <= S_SQ;
				end
				S_SQ: begin
					s_q <= SW'(mx_q) * SW'(mx_q) + SW'(my_q) * SW'(my_q);
					rem_q <= '0; root_q <= '0; cnt_q <= '0;
					if (SW'(mx_q) * SW'(mx_q) + SW'(my_q) * SW'(my_q) > sq_lim)
						st_q <= S_ROOT;
					else
						st_q <= S_DONE;
				end
				S_ROOT: begin
					s_q <= s_q << 2;
					if (rt_rem_sh >= rt_trial) begin
						rem_q <= rt_rem_sh - rt_trial;
						root_q <= {root_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rt_rem_sh;
						root_q <= {root_q[QW-2:0], 1'b0};
					end
					if (cnt_q == CW'(QW - 1)) begin
						cnt_q <= '0;
						st_q <= S_DIVL;
					end else cnt_q <= cnt_q + CW'(1);
				end
				S_LSC: begin
					mx_q <= MW'(plx >> FRAC_BITS);
					my_q <= MW'(ply >> FRAC_BITS);
					st_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/velocity_command_saturator.sv */
//------------------------------------------------------------------------------
// velocity_command_saturator
// limits planar velocity commands against configured maxima
//------------------------------------------------------------------------------
// Input beats arrive on in_valid/in_stall carrying forward, sideways and turn
// values in signed Q8.16; every input beat yields exactly one output beat on
// out_valid/out_stall. Limits are written on cfg_valid/cfg_ready by register
// index; the user must write them only while the block is idle, which the
// block itself does not enforce. The front accepts a beat into a two-entry
// queue in the cycle it arrives unless the queue is full; the back sequencer
// then runs three serial ratio divisions (one quotient bit per cycle), a
// scaling step and the sum of squares; when the norm limit applies it adds a
// square root, a fourth division and a rescale. The back takes one command at
// a time and starts the next only when the output slot is free or its beat is
// being taken. The output register holds a finished beat while the receiver
// stalls; the queue keeps accepting until it is full, then in_stall rises.
// Reset clears the queue, the sequencer and the output valid, and loads the
// register reset values.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module velocity_command_saturator #(
	parameter int VEL_WIDTH = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  vcs_pkg::cmd_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output vcs_pkg::cmd_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	localparam int LW = VEL_WIDTH - 1;
	logic [LW-1:0] fwd_q, bwd_q, side_q, lin_q, turn_q;
	logic prop_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= LW'(65536); bwd_q <= LW'(65536); side_q <= '0;
			lin_q <= LW'(65536); turn_q <= LW'(65536); prop_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				vcs_pkg::REG_FWD:  fwd_q  <= cfg_data[LW-1:0];
				vcs_pkg::REG_BWD:  bwd_q  <= cfg_data[LW-1:0];
				vcs_pkg::REG_SIDE: side_q <= cfg_data[LW-1:0];
				vcs_pkg::REG_LIN:  lin_q  <= cfg_data[LW-1:0];
				vcs_pkg::REG_TURN: turn_q <= cfg_data[LW-1:0];
				vcs_pkg::REG_PROP: prop_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: queue of accepted beats
	logic q_full, q_empty, q_pop, busy, done;
	vcs_pkg::cmd_in_t q_rd;
	assign in_stall = q_full;

	vcs_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(in_valid && !q_full), .wdata(in_data),
		.full(q_full), .pop(q_pop), .empty(q_empty), .rdata(q_rd)
	);

	// back may start when the output slot is free or is being taken
	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign q_pop = !q_empty && !busy && !done && out_free;

	logic signed [VEL_WIDTH-1:0] fx_o, fy_o, w_o;
	vcs_core #(.VEL_WIDTH(VEL_WIDTH), .FRAC_BITS(FRAC_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(q_pop),
		.fx_i(q_rd.forward_in), .fy_i(q_rd.sideways_in), .w_i(q_rd.turn_in),
		.lim_f(fwd_q), .lim_b(bwd_q), .lim_s(side_q), .lim_l(lin_q), .lim_t(turn_q),
		.prop(prop_q), .busy(busy), .done(done), .fx_o(fx_o), .fy_o(fy_o), .w_o(w_o)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (done) out_valid <= 1'b1;
		else if (out_free) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (done) begin
			out_data.forward_out  <= fx_o;
			out_data.sideways_out <= fy_o;
			out_data.turn_out     <= w_o;
		end
	end
endmodule

/* hdl/vcs_checker.sv */
//------------------------------------------------------------------------------
// vcs_checker
// port-level checks on the saturator, bound to the top level
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vcs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input vcs_pkg::cmd_out_t out_data
);
	// waiting beats and most negative results
	logic in_wait, out_wait, fwd_low, side_low;
	assign in_wait  = in_valid && in_stall;
	assign out_wait = out_valid && out_stall;
	assign fwd_low  = out_data.forward_out == {1'b1, {(vcs_pkg::VW-1){1'b0}}};
	assign side_low = out_data.sideways_out == {1'b1, {(vcs_pkg::VW-1){1'b0}}};

	`CHK_IMPL(a_in_hold, clk, arst_n, in_wait, in_valid, "stalled input beat dropped")
	`CHK_IMPL(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(out_data), "out beat moved")
	`CHK_ALWAYS(a_fwd_mag, clk, arst_n, !(out_valid && fwd_low), "forward result out of range")
	`CHK_ALWAYS(a_side_mag, clk, arst_n, !(out_valid && side_low), "sideways result out of range")
endmodule

bind velocity_command_saturator vcs_checker u_vcs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

/* dv/tb_velocity_command_saturator.sv */
//------------------------------------------------------------------------------
// tb_velocity_command_saturator
// self-checking bench for the velocity command saturator: a queue-fed driver
// and a clocked monitor compare every output beat against a bit-exact
// prediction of the limiting, across several limit settings and both modes
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_velocity_command_saturator;
	localparam int VW = vcs_pkg::VW;
	localparam int FB = vcs_pkg::FB;
	localparam int LW = vcs_pkg::LW;
	localparam int RATIO_ONE = 1 << FB;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [2:0] REG_UNKNOWN = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	vcs_pkg::cmd_in_t in_data;
	logic out_valid;
	logic out_stall;
	vcs_pkg::cmd_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	// limit registers as the predictor sees them
	logic [LW-1:0] lim_fwd, lim_bwd, lim_side, lim_lin, lim_turn;
	logic prop_mode;

	vcs_pkg::cmd_in_t pending_cmds[$];
	vcs_pkg::cmd_out_t limited_cmds[$];
	int mismatches;
	int idle_cycles;
	int in_gap, out_gap;

	velocity_command_saturator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint unsigned mag_of(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint scale_by(longint v, longint unsigned r);
		longint unsigned p;
		p = (mag_of(v) * r) >> FB;
		return v < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint unsigned sym_ratio(longint v, longint unsigned lim);
		longint unsigned m;
		m = mag_of(v);
		if (m > lim) return (lim << FB) / m;
		return RATIO_ONE;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// limited command for one requested command
	function automatic vcs_pkg::cmd_out_t limit_cmd(vcs_pkg::cmd_in_t c);
		longint fx, fy, w;
		longint unsigned rx, ry, rw, r, ax, ay, s, n;
		vcs_pkg::cmd_out_t o;
		fx = longint'(c.forward_in);
		fy = longint'(c.sideways_in);
		w = longint'(c.turn_in);
		rx = RATIO_ONE;
		if (fx > longint'(lim_fwd)) rx = (longint'(lim_fwd) << FB) / fx;
		ry = sym_ratio(fy, lim_side);
		rw = sym_ratio(w, lim_turn);
		if (lim_bwd != 0 && fx < -longint'(lim_bwd))
			rx = (longint'(lim_bwd) << FB) / mag_of(fx);
		if (prop_mode) begin
			r = rx;
			if (ry < r) r = ry;
			if (rw < r) r = rw;
			fx = scale_by(fx, r);
			fy = scale_by(fy, r);
			w = scale_by(w, r);
		end else begin
			fx = scale_by(fx, rx);
			fy = scale_by(fy, ry);
			w = scale_by(w, rw);
		end
		ax = mag_of(fx);
		ay = mag_of(fy);
		s = ax * ax + ay * ay;
		if (s > longint'(lim_lin) * longint'(lim_lin)) begin
			n = int_sqrt(s);
			r = (longint'(lim_lin) << FB) / n;
			fx = scale_by(fx, r);
			fy = scale_by(fy, r);
		end
		o.forward_out = fx[VW-1:0];
		o.sideways_out = fy[VW-1:0];
		o.turn_out = w[VW-1:0];
		return o;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch %s", msg);
		mismatches++;
	endtask

	task automatic add_cmd(vcs_pkg::cmd_in_t c);
		pending_cmds = {pending_cmds, c};
	endtask

	// driver: feed input beats from the pending queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				limited_cmds = {limited_cmds, limit_cmd(in_data)};
				void'(pending_cmds.pop_front());
			end
			if (in_valid && in_stall) begin
				// hold the stalled beat
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_cmds[0];
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check output beats and drive random stall
	always @(posedge clk or negedge arst_n) begin
		vcs_pkg::cmd_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (limited_cmds.size() == 0) begin
					report_mismatch($sformatf("unexpected output beat %h", out_data));
				end else begin
					want = limited_cmds.pop_front();
					if (out_data.forward_out !== want.forward_out)
						report_mismatch($sformatf("forward: got %h expected %h",
							out_data.forward_out, want.forward_out));
					if (out_data.sideways_out !== want.sideways_out)
						report_mismatch($sformatf("sideways: got %h expected %h",
							out_data.sideways_out, want.sideways_out));
					if (out_data.turn_out !== want.turn_out)
						report_mismatch($sformatf("turn: got %h expected %h",
							out_data.turn_out, want.turn_out));
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				out_gap <= pick_gap();
			end
		end
	end

	// watchdog on cycles with no accepted beat or register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			vcs_pkg::REG_FWD: lim_fwd = val[LW-1:0];
			vcs_pkg::REG_BWD: lim_bwd = val[LW-1:0];
			vcs_pkg::REG_SIDE: lim_side = val[LW-1:0];
			vcs_pkg::REG_LIN: lim_lin = val[LW-1:0];
			vcs_pkg::REG_TURN: lim_turn = val[LW-1:0];
			vcs_pkg::REG_PROP: prop_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || limited_cmds.size() != 0 || in_valid)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [VW-1:0] rand_vel(logic [LW-1:0] lim);
		int sel;
		logic [VW-1:0] v;
		sel = $urandom_range(0, 9);
		if (sel < 2) v = VW'($urandom());
		else if (sel < 4)
			v = VW'(int'($urandom_range(0, 2 * lim + 2)) - int'(lim) - 1);
		else if (sel == 4) v = {1'b1, {(VW-1){1'b0}}};
		else if (sel == 5) v = {1'b0, {(VW-1){1'b1}}};
		else v = VW'(int'($urandom_range(0, 4 * RATIO_ONE)) - 2 * RATIO_ONE);
		return v;
	endfunction

	function automatic logic [LW-1:0] rand_lim();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return '0;
		if (sel == 1) return '1;
		if (sel < 4) return LW'($urandom());
		return LW'($urandom_range(1, 4 * RATIO_ONE));
	endfunction

	function automatic vcs_pkg::cmd_in_t mk_cmd(int f, int s, int t);
		vcs_pkg::cmd_in_t c;
		c.forward_in = VW'(f);
		c.sideways_in = VW'(s);
		c.turn_in = VW'(t);
		return c;
	endfunction

	initial begin
		logic [VW-1:0] vmin, vmax;
		vmin = {1'b1, {(VW-1){1'b0}}};
		vmax = {1'b0, {(VW-1){1'b1}}};
		mismatches = 0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		lim_fwd = 65536; lim_bwd = 65536; lim_side = 0;
		lim_lin = 65536; lim_turn = 65536; prop_mode = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limits, field extremes, most negative value
		add_cmd(mk_cmd(0, 0, 0));
		add_cmd(mk_cmd(vmax, vmax, vmax));
		add_cmd(mk_cmd(vmin, vmin, vmin));
		add_cmd(mk_cmd(65536, 0, -65536));
		add_cmd(mk_cmd(-65537, 1, 65537));
		add_cmd(mk_cmd(46341, 0, 0));
		drain();
		// norm under the limit, backward check disabled, proportional mode
		write_reg(vcs_pkg::REG_SIDE, 65536);
		write_reg(vcs_pkg::REG_BWD, 0);
		write_reg(vcs_pkg::REG_PROP, 1);
		add_cmd(mk_cmd(39321, 26214, 0));
		add_cmd(mk_cmd(-3000000, 0, 0));
		add_cmd(mk_cmd(200000, -100000, 300000));
		add_cmd(mk_cmd(vmin, vmax, 5));
		drain();
		// zero limits everywhere but the backward limit, which is one
		write_reg(vcs_pkg::REG_FWD, 0);
		write_reg(vcs_pkg::REG_BWD, 1);
		write_reg(vcs_pkg::REG_SIDE, 0);
		write_reg(vcs_pkg::REG_TURN, 0);
		write_reg(vcs_pkg::REG_LIN, 0);
		add_cmd(mk_cmd(vmax, vmin, 7));
		add_cmd(mk_cmd(-1, 1, -1));
		drain();
		// largest limits, ignored unknown index
		write_reg(vcs_pkg::REG_FWD, 32'hFFFF_FFFF);
		write_reg(vcs_pkg::REG_BWD, 32'hFFFF_FFFF);
		write_reg(vcs_pkg::REG_SIDE, 32'hFFFF_FFFF);
		write_reg(vcs_pkg::REG_TURN, 32'hFFFF_FFFF);
		write_reg(vcs_pkg::REG_LIN, 32'hFFFF_FFFF);
		write_reg(REG_UNKNOWN, 32'h1234);
		add_cmd(mk_cmd(vmax, vmax, vmin));
		add_cmd(mk_cmd(vmin, vmin, vmax));
		drain();

		// random phases, each with its own limit setting
		for (int ph = 0; ph < 14; ph++) begin
			write_reg(vcs_pkg::REG_FWD, 32'(rand_lim()));
			write_reg(vcs_pkg::REG_BWD,
				$urandom_range(0, 3) == 0 ? 32'd0 : 32'(rand_lim()));
			write_reg(vcs_pkg::REG_SIDE, 32'(rand_lim()));
			write_reg(vcs_pkg::REG_LIN, 32'(rand_lim()));
			write_reg(vcs_pkg::REG_TURN, 32'(rand_lim()));
			write_reg(vcs_pkg::REG_PROP, $urandom_range(0, 1));
			for (int i = 0; i < 100; i++)
				add_cmd(mk_cmd(rand_vel(lim_fwd), rand_vel(lim_side),
					rand_vel(lim_turn)));
			drain();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
